FILE: hdl/display_serial_frame_decoder_macros.svh
// Assertion macros used by the checker of the display serial frame decoder.
`ifndef DISPLAY_SERIAL_FRAME_DECODER_MACROS_SVH
`define DISPLAY_SERIAL_FRAME_DECODER_MACROS_SVH

// Implication that is checked only while the block is out of reset.
`define DSFD_ASSERT_IMPL(lbl, clk_sig, rstn_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error("display serial frame decoder assertion failed");

// Condition that is checked at every rising clock edge, reset included.
`define DSFD_ASSERT_ALWAYS(lbl, clk_sig, cond) \
	lbl: assert property (@(posedge clk_sig) (cond)) \
		else $error("display serial frame decoder assertion failed");

`endif

FILE: hdl/dsfd_pkg.sv
// Shared types and constants of the display serial frame decoder.
package dsfd_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_HIGH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_REG_CODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_MEM_CODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS    = 3'd4;

	localparam logic [7:0] HEADER_HIGH_RST   = 8'h5A;
	localparam logic [7:0] HEADER_LOW_RST    = 8'hA5;
	localparam logic [7:0] READ_REG_CODE_RST = 8'h81;
	localparam logic [7:0] READ_MEM_CODE_RST = 8'h83;
	localparam logic [3:0] IDLE_TICKS_RST    = 4'd4;

	localparam int MIN_FRAME = 4;

	typedef struct packed {
		logic [7:0] header_high;
		logic [7:0] header_low;
		logic [7:0] read_register_code;
		logic [7:0] read_memory_code;
		logic [3:0] idle_ticks;
	} cfg_t;

endpackage

FILE: hdl/dsfd_front.sv
// Receive side: byte ring, idle countdown and frame cut on the timer tick.
module dsfd_front #(
	parameter int DEPTH = 64,
	parameter int PW = 6,
	parameter int CW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dsfd_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [7:0]       rx_byte,
	input  logic             line_error,
	output logic             job_valid,
	input  logic             job_ready,
	output logic [PW-1:0]    job_ptr,
	output logic [CW-1:0]    job_len,
	input  logic             rd_en,
	input  logic [PW-1:0]    rd_addr,
	output logic [7:0]       rd_data
);
	import dsfd_pkg::*;

	localparam int SW = PW + 1;

	logic [7:0]    ring [DEPTH];
	logic [7:0]    rd_data_q;
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] backlog_q;
	logic [3:0]    cd_q;
	logic          accept;
	logic          good_byte;
	logic          store;
	logic          tick;
	logic          drain;
	logic [CW:0]   occupied;
	logic [SW-1:0] rp_sum;
	logic [PW-1:0] rp_next;

	assign occupied = (CW+1)'(count_q) + (CW+1)'(backlog_q);
	assign in_ready = job_ready && ((backlog_q == '0) || (occupied != (CW+1)'(DEPTH)));
	assign accept = in_valid && in_ready;
	assign good_byte = accept && !action && !line_error;
	assign store = good_byte && (count_q != CW'(DEPTH));
	assign tick = accept && action;
	assign drain = tick && (cd_q == '0) && (count_q >= CW'(MIN_FRAME));

	assign job_valid = drain;
	assign job_ptr = rp_q;
	assign job_len = count_q;

	assign rp_sum = SW'(rp_q) + SW'(count_q);
	assign rp_next = (rp_sum >= SW'(DEPTH)) ? PW'(rp_sum - SW'(DEPTH)) : PW'(rp_sum);

	assign rd_data = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
			backlog_q <= '0;
			cd_q <= '0;
		end else begin
			if (good_byte) begin
				cd_q <= cfg.idle_ticks;
			end else if (tick && (cd_q != '0)) begin
				cd_q <= cd_q - 4'd1;
			end
			if (drain) begin
				count_q <= '0;
				rp_q <= rp_next;
			end else if (store) begin
				count_q <= count_q + 1'b1;
			end
			if (store) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			backlog_q <= backlog_q + (drain ? count_q : '0) - (rd_en ? CW'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			ring[wp_q] <= rx_byte;
		end
		if (rd_en) begin
			rd_data_q <= ring[rd_addr];
		end
	end

endmodule

FILE: hdl/dsfd_fifo.sv
// Two-entry queue that carries cut frames from the receive side to the decoder.
module dsfd_fifo #(
	parameter int WIDTH = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import dsfd_pkg::*;

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_data = slot_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/dsfd_back.sv
// Decoder: walks one cut frame through the ring and turns it into word writes.
module dsfd_back #(
	parameter int DEPTH = 64,
	parameter int PW = 6,
	parameter int CW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dsfd_pkg::cfg_t   cfg,
	input  logic             job_valid,
	output logic             job_ready,
	input  logic [PW-1:0]    job_ptr,
	input  logic [CW-1:0]    job_len,
	output logic             rd_en,
	output logic [PW-1:0]    rd_addr,
	input  logic [7:0]       rd_data,
	output logic             m_valid,
	input  logic             m_ready,
	output logic [15:0]      m_addr,
	output logic [15:0]      m_value,
	output logic             m_last
);
	import dsfd_pkg::*;

	localparam logic [7:0]  SUB_SCREEN = 8'h03;
	localparam logic [7:0]  SUB_KEYS = 8'h20;
	localparam logic [15:0] MEM_ADDR_LIMIT = 16'd99;
	localparam logic [15:0] MEM_ADDR_OFFSET = 16'd10;
	localparam logic [15:0] KEY_BASE = 16'd11;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_REG,
		KIND_MEM
	} kind_t;

	logic          busy_q;
	logic [CW-1:0] left_q;
	logic [PW-1:0] raddr_q;
	logic [CW-1:0] issue_idx_q;
	logic [CW-1:0] pidx_q;
	logic [CW-1:0] len_q;
	logic          dv_q;
	logic          h0ok_q;
	logic          hok_q;
	kind_t         kind_q;
	logic [7:0]    b4_q;
	logic [7:0]    b5_q;
	logic [7:0]    b6_q;
	logic [7:0]    prev_q;
	logic          out_valid_q;
	logic [15:0]   out_addr_q;
	logic [15:0]   out_value_q;
	logic          out_last_q;

	logic [15:0] idx16;
	logic [15:0] n16;
	logic [15:0] addr_a;
	logic [15:0] reg_i;
	logic [15:0] mem_i;
	logic [15:0] pair_val;
	logic [15:0] bcd_val;
	logic        need_emit;
	logic [15:0] e_addr;
	logic [15:0] e_value;
	logic        e_last;
	logic        out_free;
	logic        proc;
	logic        load;

	assign idx16 = 16'(pidx_q);
	assign n16 = 16'(len_q);
	assign addr_a = {b4_q, b5_q};
	assign reg_i = idx16 - 16'd6;
	assign mem_i = (idx16 - 16'd8) >> 1;
	assign pair_val = {prev_q, rd_data};
	assign bcd_val = 16'(rd_data[7:4]) * 16'd10 + 16'(rd_data[3:0]);

	always_comb begin
		need_emit = 1'b0;
		e_addr = '0;
		e_value = pair_val;
		e_last = 1'b1;
		case (kind_q)
			KIND_REG: begin
				if (b4_q == SUB_SCREEN) begin
					need_emit = (idx16 == 16'd7);
				end else if (b4_q == SUB_KEYS) begin
					need_emit = (idx16 >= 16'd6) && (reg_i < 16'(b5_q));
					e_addr = KEY_BASE + reg_i;
					e_value = bcd_val;
					e_last = (reg_i + 16'd1 == 16'(b5_q)) || (idx16 + 16'd1 == n16);
				end
			end
			KIND_MEM: begin
				if (addr_a > MEM_ADDR_LIMIT) begin
					need_emit = (idx16 == 16'd8);
					e_addr = addr_a - MEM_ADDR_OFFSET;
				end else begin
					need_emit = (idx16 >= 16'd8) && !idx16[0] && (mem_i < 16'(b6_q));
					e_addr = addr_a + mem_i;
					e_last = (mem_i + 16'd1 == 16'(b6_q)) || (idx16 + 16'd2 >= n16);
				end
			end
			default: begin
				need_emit = 1'b0;
			end
		endcase
		need_emit = need_emit && hok_q;
	end

	assign out_free = !out_valid_q || m_ready;
	assign proc = dv_q && (!need_emit || out_free);
	assign rd_en = busy_q && (left_q != '0) && (!dv_q || proc);
	assign rd_addr = raddr_q;
	assign job_ready = !busy_q;
	assign load = job_valid && !busy_q;

	assign m_valid = out_valid_q;
	assign m_addr = out_addr_q;
	assign m_value = out_value_q;
	assign m_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
			raddr_q <= '0;
			issue_idx_q <= '0;
			pidx_q <= '0;
			len_q <= '0;
			dv_q <= 1'b0;
			h0ok_q <= 1'b0;
			hok_q <= 1'b0;
			kind_q <= KIND_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				left_q <= job_len;
				raddr_q <= job_ptr;
				issue_idx_q <= '0;
				len_q <= job_len;
			end else if (busy_q && (left_q == '0) && (!dv_q || proc)) begin
				busy_q <= 1'b0;
			end
			if (rd_en) begin
				left_q <= left_q - 1'b1;
				raddr_q <= (raddr_q == PW'(DEPTH - 1)) ? '0 : raddr_q + 1'b1;
				issue_idx_q <= issue_idx_q + 1'b1;
				pidx_q <= issue_idx_q;
				dv_q <= 1'b1;
			end else if (proc) begin
				dv_q <= 1'b0;
			end
			if (proc) begin
				case (idx16)
					16'd0: h0ok_q <= (rd_data == cfg.header_high);
					16'd1: hok_q <= h0ok_q && (rd_data == cfg.header_low);
					16'd3: begin
						if (rd_data == cfg.read_register_code) begin
							kind_q <= KIND_REG;
						end else if (rd_data == cfg.read_memory_code) begin
							kind_q <= KIND_MEM;
						end else begin
							kind_q <= KIND_NONE;
						end
					end
					default: begin
					end
				endcase
			end
			if (proc && need_emit) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			prev_q <= rd_data;
			if (idx16 == 16'd4) begin
				b4_q <= rd_data;
			end
			if (idx16 == 16'd5) begin
				b5_q <= rd_data;
			end
			if (idx16 == 16'd6) begin
				b6_q <= rd_data;
			end
		end
		if (proc && need_emit) begin
			out_addr_q <= e_addr;
			out_value_q <= e_value;
			out_last_q <= e_last;
		end
	end

endmodule

FILE: hdl/display_serial_frame_decoder.sv
// Top level of the display serial frame decoder: configuration registers, front, queue, decoder.
// Each input word is a received byte or a timer tick. Good bytes go into a receive ring of
// BUFFER_DEPTH bytes; a tick that finds the idle countdown at zero with at least four bytes held
// cuts them off as one frame of n bytes and queues it for the decoder. The decoder reads the ring
// through its single registered read port, one byte per cycle while the sink keeps up, and yields
// at most one word write per cycle. Input words keep flowing while a frame is decoded; the input
// stalls only when two frames wait in the queue or when the ring is full of bytes the decoder has
// not read yet, counting the frame being gathered, and at least one of those bytes belongs to a cut
// frame. Configuration writes are accepted in every cycle.
module display_serial_frame_decoder #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // rx_byte
	input  logic [1:0]                     s_tuser,   // action, line_error
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // word_address, word_value
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dsfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import dsfd_pkg::*;

	localparam int PW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);

	cfg_t          cfg_q;
	logic          job_push_valid;
	logic          job_push_ready;
	logic [PW-1:0] job_push_ptr;
	logic [CW-1:0] job_push_len;
	logic          job_pop_valid;
	logic          job_pop_ready;
	logic [PW-1:0] job_pop_ptr;
	logic [CW-1:0] job_pop_len;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic [15:0]   word_address;
	logic [15:0]   word_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_high <= HEADER_HIGH_RST;
			cfg_q.header_low <= HEADER_LOW_RST;
			cfg_q.read_register_code <= READ_REG_CODE_RST;
			cfg_q.read_memory_code <= READ_MEM_CODE_RST;
			cfg_q.idle_ticks <= IDLE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER_HIGH: cfg_q.header_high <= cfg_data;
				CFG_HEADER_LOW: cfg_q.header_low <= cfg_data;
				CFG_READ_REG_CODE: cfg_q.read_register_code <= cfg_data;
				CFG_READ_MEM_CODE: cfg_q.read_memory_code <= cfg_data;
				CFG_IDLE_TICKS: cfg_q.idle_ticks <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	dsfd_front #(
		.DEPTH(BUFFER_DEPTH),
		.PW(PW),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.action(s_tuser[0]),
		.rx_byte(s_tdata),
		.line_error(s_tuser[1]),
		.job_valid(job_push_valid),
		.job_ready(job_push_ready),
		.job_ptr(job_push_ptr),
		.job_len(job_push_len),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	dsfd_fifo #(
		.WIDTH(PW + CW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(job_push_valid),
		.push_ready(job_push_ready),
		.push_data({job_push_ptr, job_push_len}),
		.pop_valid(job_pop_valid),
		.pop_ready(job_pop_ready),
		.pop_data({job_pop_ptr, job_pop_len})
	);

	dsfd_back #(
		.DEPTH(BUFFER_DEPTH),
		.PW(PW),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_valid(job_pop_valid),
		.job_ready(job_pop_ready),
		.job_ptr(job_pop_ptr),
		.job_len(job_pop_len),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_addr(word_address),
		.m_value(word_value),
		.m_last(m_tlast)
	);

	assign m_tdata = {word_value, word_address};

endmodule

FILE: hdl/dsfd_checker.sv
// Port-level checker of the display serial frame decoder and its bind statement.
`include "display_serial_frame_decoder_macros.svh"

module dsfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_ready
);
	import dsfd_pkg::*;

	`DSFD_ASSERT_IMPL(a_out_hold, clk, arst_n, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
	`DSFD_ASSERT_ALWAYS(a_no_word_in_reset, clk, arst_n || (m_tvalid !== 1'b1))
	`DSFD_ASSERT_ALWAYS(a_cfg_always_ready, clk, cfg_ready)

endmodule

bind display_serial_frame_decoder dsfd_checker u_dsfd_checker (.*);
